/* sv/sida_pkg.sv */
package sida_pkg;

   // Word and digit geometry
   localparam int WORD_W         = 32;
   localparam int DIGITS         = 10;
   localparam int BCD_W          = 4 * DIGITS;
   localparam int BITS_PER_STAGE = 8;
   localparam int DD_STAGES      = WORD_W / BITS_PER_STAGE;
   localparam int POS_W          = 4;
   localparam int CHAR_W         = 8;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BCD_W-1:0]  bcd_type;
   typedef logic [POS_W-1:0]  pos_type;

   // Add 3 to every BCD digit of 5 or more ahead of the next shift
   function automatic bcd_type dabble_adjust(input bcd_type bcd);
      bcd_type r;
      r = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (r[4*d +: 4] >= 4'd5) begin
            r[4*d +: 4] = r[4*d +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

endpackage

/* sv/signed_int_to_decimal_ascii_unit.sv */
// Channel   Ports                                      Handshake
// -------   -----------------------------------------  ---------------------------------
// request   req_value                                  taken when start & !busy
// response  rsp_character, rsp_last                    one character per rsp_valid cycle
//
// A value is taken into a six-stage pipeline: magnitude, four stages of eight
// shift-and-add-3 steps each, and a leading-digit count. A serializer then
// sends one character per cycle: the sign of a negative value, then its
// digits from the leading nonzero one down, 1 to 11 characters in all. The
// serializer sets the sustained rate; busy rises only when every pipeline
// stage holds a value behind it. Reset is synchronous and clears the valid
// bits; the receiver cannot stall the response port.
module signed_int_to_decimal_ascii_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [sida_pkg::WORD_W-1:0] req_value,
   output logic                             rsp_valid,
   output logic [sida_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_last
);
   import sida_pkg::*;

   // Pipeline registers: index 0 is the magnitude stage
   bcd_type  dd_bcd_ff   [DD_STAGES+1];
   word_type dd_bin_ff   [DD_STAGES+1];
   logic     dd_neg_ff   [DD_STAGES+1];
   logic     dd_valid_ff [DD_STAGES+1];
   bcd_type  dd_bcd_in   [DD_STAGES+1];
   word_type dd_bin_in   [DD_STAGES+1];

   // Count stage
   bcd_type  cnt_bcd_ff;
   pos_type  cnt_pos_ff;
   logic     cnt_neg_ff;
   logic     cnt_valid_ff;
   pos_type  cnt_pos_in;

   // Serializer
   bcd_type  ser_bcd_ff;
   pos_type  ser_pos_ff;
   logic     ser_sign_ff;
   logic     ser_active_ff;
   pos_type  ser_pos_in;
   logic     ser_sign_in;
   logic     ser_active_in;
   logic     ser_end;
   logic     ser_take;

   // Stage free flags: 0..DD_STAGES pipeline, DD_STAGES+1 count stage
   logic     pipe_free [DD_STAGES+2];

   // Serializer finishes a word this cycle or is empty
   assign ser_end  = ser_active_ff & ~ser_sign_ff & (ser_pos_ff == '0);
   assign ser_take = ~ser_active_ff | ser_end;

   // Ripple stall backward from the serializer
   always_comb begin
      pipe_free[DD_STAGES+1] = ~cnt_valid_ff | ser_take;
      for (int k = DD_STAGES; k >= 0; k--) begin
         pipe_free[k] = ~dd_valid_ff[k] | pipe_free[k+1];
      end
   end

   assign busy = ~pipe_free[0];

   // Form the magnitude in unsigned arithmetic
   always_comb begin
      dd_bcd_in[0] = '0;
      if (req_value[WORD_W-1]) begin
         dd_bin_in[0] = word_type'(0) - word_type'(req_value);
      end else begin
         dd_bin_in[0] = word_type'(req_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dd_valid_ff[0] <= 1'b0;
      end else if (pipe_free[0]) begin
         dd_valid_ff[0] <= start;
      end
      if (pipe_free[0]) begin
         dd_bcd_ff[0] <= dd_bcd_in[0];
         dd_bin_ff[0] <= dd_bin_in[0];
         dd_neg_ff[0] <= req_value[WORD_W-1];
      end
   end

   // Shift-and-add-3 stages, eight bits each
   for (genvar k = 1; k <= DD_STAGES; k++) begin : g_dabble
      always_comb begin
         bcd_type  bcd;
         word_type bin;
         bcd = dd_bcd_ff[k-1];
         bin = dd_bin_ff[k-1];
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            bcd = dabble_adjust(bcd);
            bcd = {bcd[BCD_W-2:0], bin[WORD_W-1]};
            bin = {bin[WORD_W-2:0], 1'b0};
         end
         dd_bcd_in[k] = bcd;
         dd_bin_in[k] = bin;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dd_valid_ff[k] <= 1'b0;
         end else if (pipe_free[k]) begin
            dd_valid_ff[k] <= dd_valid_ff[k-1];
         end
         if (pipe_free[k]) begin
            dd_bcd_ff[k] <= dd_bcd_in[k];
            dd_bin_ff[k] <= dd_bin_in[k];
            dd_neg_ff[k] <= dd_neg_ff[k-1];
         end
      end
   end

   // Find the top nonzero digit; zero keeps a single digit
   always_comb begin
      cnt_pos_in = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (dd_bcd_ff[DD_STAGES][4*i +: 4] != 4'd0) begin
            cnt_pos_in = POS_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
      end else if (pipe_free[DD_STAGES+1]) begin
         cnt_valid_ff <= dd_valid_ff[DD_STAGES];
      end
      if (pipe_free[DD_STAGES+1]) begin
         cnt_bcd_ff <= dd_bcd_ff[DD_STAGES];
         cnt_pos_ff <= cnt_pos_in;
         cnt_neg_ff <= dd_neg_ff[DD_STAGES];
      end
   end

   // Load a new word or advance through sign and digits
   always_comb begin
      ser_active_in = ser_active_ff;
      ser_sign_in   = ser_sign_ff;
      ser_pos_in    = ser_pos_ff;
      if (ser_take && cnt_valid_ff) begin
         ser_active_in = 1'b1;
         ser_sign_in   = cnt_neg_ff;
         ser_pos_in    = cnt_pos_ff;
      end else if (ser_active_ff) begin
         if (ser_sign_ff) begin
            ser_sign_in = 1'b0;
         end else if (ser_end) begin
            ser_active_in = 1'b0;
         end else begin
            ser_pos_in = ser_pos_ff - pos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_active_ff <= 1'b0;
         ser_sign_ff   <= 1'b0;
      end else begin
         ser_active_ff <= ser_active_in;
         ser_sign_ff   <= ser_sign_in;
      end
      ser_pos_ff <= ser_pos_in;
      if (ser_take && cnt_valid_ff) begin
         ser_bcd_ff <= cnt_bcd_ff;
      end
   end

   // Drive the response word
   assign rsp_valid     = ser_active_ff;
   assign rsp_last      = ser_end;
   assign rsp_character = ser_sign_ff ? CHAR_MINUS
                        : (CHAR_ZERO | {4'h0, ser_bcd_ff[{ser_pos_ff, 2'b00} +: 4]});

endmodule

/* sv/sida_checker.sv */
module sida_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic [sida_pkg::CHAR_W-1:0] rsp_character,
   input logic                        rsp_last
);
   import sida_pkg::*;

   // Characters of one text run back to back, and a sign only opens it
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_character != CHAR_MINUS)
      else $error("text run broken or sign inside a run");

   // Only a sign or a decimal digit is sent
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_character == CHAR_MINUS
                 || (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE))
      else $error("illegal character");

   // A sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("sign flagged as last");

   // A negative value has a nonzero leading digit
   a_no_neg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |=> rsp_character != CHAR_ZERO)
      else $error("leading zero after sign");

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker u_sida_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
